[rtl/qpf_pkg.sv]
package qpf_pkg;

    // default build of the chain
    localparam int DEF_WINDOW_LEN  = 30;
    localparam int DEF_SAMPLE_BITS = 16;

    // words held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // headroom of the low-pass input term over the sample width
    localparam int LQ_EXTRA = 2;

    // fill state of the queue as seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/qpf_front.sv]
module qpf_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int LQ_W        = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] raw_sample,
    input  qpf_pkg::q_status_t            q_status,
    output logic                          push,
    output logic signed [LQ_W-1:0]        push_data
);
    import qpf_pkg::*;

    localparam int HIST = 12;

    logic signed [SAMPLE_BITS-1:0] rh_reg [HIST];
    logic signed [LQ_W-1:0]        x_ext;
    logic signed [LQ_W-1:0]        rh5_ext;
    logic signed [LQ_W-1:0]        rh11_ext;
    logic signed [LQ_W-1:0]        lq_sum;
    logic signed [LQ_W-1:0]        lq_bias;

    // take a word whenever the queue has room
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // x - 2*x6 + x12, then divide by 32 toward zero
    assign x_ext    = {{(LQ_W-SAMPLE_BITS){raw_sample[SAMPLE_BITS-1]}}, raw_sample};
    assign rh5_ext  = {{(LQ_W-SAMPLE_BITS){rh_reg[5][SAMPLE_BITS-1]}}, rh_reg[5]};
    assign rh11_ext = {{(LQ_W-SAMPLE_BITS){rh_reg[11][SAMPLE_BITS-1]}}, rh_reg[11]};
    assign lq_sum   = x_ext - (rh5_ext <<< 1) + rh11_ext;
    assign lq_bias  = {{(LQ_W-5){1'b0}}, {5{lq_sum[LQ_W-1]}}};
    assign push_data = (lq_sum + lq_bias) >>> 5;

    // raw sample delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                rh_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            for (int i = HIST-1; i > 0; i--)
            begin
                rh_reg[i] <= rh_reg[i-1];
            end
            rh_reg[0] <= raw_sample;
        end
    end

endmodule

[rtl/qpf_queue.sv]
module qpf_queue #(
    parameter int DATA_W = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DATA_W-1:0]   push_data,
    input  logic                pop,
    output logic [DATA_W-1:0]   head,
    output qpf_pkg::q_status_t  q_status
);
    import qpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/qpf_back.sv]
module qpf_back #(
    parameter int WINDOW_LEN = 30,
    parameter int LQ_W       = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qpf_pkg::q_status_t     q_status,
    input  logic signed [LQ_W-1:0] head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [63:0]     low_passed,
    output logic signed [31:0]     high_passed,
    output logic signed [31:0]     slope,
    output logic signed [31:0]     squared,
    output logic signed [31:0]     integrated
);
    import qpf_pkg::*;

    localparam int          STAGES     = 10;
    localparam int          LP_HIST    = 32;
    localparam int          HP_HIST    = 4;
    localparam logic [63:0] RECIP_FULL = 64'hFFFF_FFFF / 64'(WINDOW_LEN);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [31:0] WIN        = 32'(WINDOW_LEN);

    // divide a 64-bit signed value by 32 toward zero
    function automatic logic signed [63:0] div32_s64(input logic signed [63:0] v);
        logic signed [63:0] bias;
        bias = {59'b0, {5{v[63]}}};
        return (v + bias) >>> 5;
    endfunction

    logic [STAGES:1]    v_reg;
    logic               adv;
    logic [STAGES:1]    fire;

    // stage 1: low-pass recursion
    logic signed [63:0] lq_ext;
    logic signed [63:0] lp1_reg;
    logic signed [63:0] lp1_next;
    logic signed [63:0] y2_reg;

    // stage 2: feed-forward part of the high-pass
    logic signed [63:0] lh_reg [LP_HIST];
    logic signed [63:0] lp2_reg;
    logic [31:0]        part_next;
    logic [31:0]        part2_reg;
    logic signed [63:0] lh31_div;
    logic signed [63:0] lp_div;

    // stage 3: high-pass recursion
    logic signed [63:0] lp3_reg;
    logic signed [31:0] hp3_reg;

    // stage 4: derivative
    logic signed [31:0] hh_reg [HP_HIST];
    logic signed [34:0] d_sum;
    logic signed [34:0] d_quot;
    logic signed [63:0] lp4_reg;
    logic signed [31:0] hp4_reg;
    logic signed [31:0] dv4_reg;

    // stage 5: square
    logic [63:0]        sq_prod;
    logic signed [63:0] lp5_reg;
    logic signed [31:0] hp5_reg;
    logic signed [31:0] dv5_reg;
    logic signed [31:0] sq5_reg;

    // stage 6: running window sum
    logic [31:0]        sl_reg [WINDOW_LEN];
    logic [31:0]        acc6_reg;
    logic signed [63:0] lp6_reg;
    logic signed [31:0] hp6_reg;
    logic signed [31:0] dv6_reg;
    logic signed [31:0] sq6_reg;

    // stages 7 to 10: signed division by the window length
    logic [31:0]        mag7_reg;
    logic               neg7_reg;
    logic signed [63:0] lp7_reg;
    logic signed [31:0] hp7_reg;
    logic signed [31:0] dv7_reg;
    logic signed [31:0] sq7_reg;

    logic [63:0]        prod8_reg;
    logic [31:0]        mag8_reg;
    logic               neg8_reg;
    logic signed [63:0] lp8_reg;
    logic signed [31:0] hp8_reg;
    logic signed [31:0] dv8_reg;
    logic signed [31:0] sq8_reg;

    logic [31:0]        q0_est;
    logic [31:0]        q9_reg;
    logic [31:0]        r9_reg;
    logic               neg9_reg;
    logic signed [63:0] lp9_reg;
    logic signed [31:0] hp9_reg;
    logic signed [31:0] dv9_reg;
    logic signed [31:0] sq9_reg;

    logic               q_fix;
    logic [31:0]        avg_next;
    logic signed [63:0] lp10_reg;
    logic signed [31:0] hp10_reg;
    logic signed [31:0] dv10_reg;
    logic signed [31:0] sq10_reg;
    logic signed [31:0] avg10_reg;

    // the whole line moves unless the output word is held
    assign adv  = !(v_reg[STAGES] && out_stall);
    assign pop  = adv && !q_status.empty;
    assign fire = adv ? v_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-1:1], !q_status.empty};
        end
    end

    // low-pass: 2*y1 - y2 + lq
    assign lq_ext   = {{(64-LQ_W){head[LQ_W-1]}}, head};
    assign lp1_next = (lp1_reg <<< 1) - y2_reg + lq_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp1_reg <= '0;
            y2_reg  <= '0;
        end
        else if (pop)
        begin
            lp1_reg <= lp1_next;
            y2_reg  <= lp1_reg;
        end
    end

    // high-pass terms that do not feed back, kept to the low 32 bits
    assign lh31_div  = div32_s64(lh_reg[31]);
    assign lp_div    = div32_s64(lp1_reg);
    assign part_next = lh_reg[15][31:0] - lh_reg[16][31:0] + lh31_div[31:0] - lp_div[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LP_HIST; i++)
            begin
                lh_reg[i] <= '0;
            end
        end
        else if (fire[1])
        begin
            for (int i = LP_HIST-1; i > 0; i--)
            begin
                lh_reg[i] <= lh_reg[i-1];
            end
            lh_reg[0] <= lp1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp2_reg   <= lp1_reg;
            part2_reg <= part_next;
        end
    end

    // high-pass feedback in 32 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp3_reg <= '0;
        end
        else if (fire[2])
        begin
            hp3_reg <= hp3_reg + $signed(part2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp3_reg <= lp2_reg;
        end
    end

    // derivative: (2x + x1 - x3 - 2x4) / 8 toward zero
    assign d_sum  = ({{3{hp3_reg[31]}}, hp3_reg} <<< 1)
                  + {{3{hh_reg[0][31]}}, hh_reg[0]}
                  - {{3{hh_reg[2][31]}}, hh_reg[2]}
                  - ({{3{hh_reg[3][31]}}, hh_reg[3]} <<< 1);
    assign d_quot = (d_sum + {32'b0, {3{d_sum[34]}}}) >>> 3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HP_HIST; i++)
            begin
                hh_reg[i] <= '0;
            end
        end
        else if (fire[3])
        begin
            for (int i = HP_HIST-1; i > 0; i--)
            begin
                hh_reg[i] <= hh_reg[i-1];
            end
            hh_reg[0] <= hp3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp4_reg <= lp3_reg;
            hp4_reg <= hp3_reg;
            dv4_reg <= d_quot[31:0];
        end
    end

    // square, low word only
    assign sq_prod = {32'b0, dv4_reg} * {32'b0, dv4_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp5_reg <= lp4_reg;
            hp5_reg <= hp4_reg;
            dv5_reg <= dv4_reg;
            sq5_reg <= sq_prod[31:0];
        end
    end

    // running sum: add the new square, drop the one a window ago
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc6_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                sl_reg[i] <= '0;
            end
        end
        else if (fire[5])
        begin
            acc6_reg <= acc6_reg - sl_reg[WINDOW_LEN-1] + sq5_reg;
            for (int i = WINDOW_LEN-1; i > 0; i--)
            begin
                sl_reg[i] <= sl_reg[i-1];
            end
            sl_reg[0] <= sq5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp6_reg <= lp5_reg;
            hp6_reg <= hp5_reg;
            dv6_reg <= dv5_reg;
            sq6_reg <= sq5_reg;
        end
    end

    // magnitude, reciprocal product, remainder, then correct and restore sign
    assign q0_est   = prod8_reg[63:32];
    assign q_fix    = (r9_reg >= WIN);
    assign avg_next = neg9_reg ? (~q9_reg + {31'b0, !q_fix}) : (q9_reg + {31'b0, q_fix});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg7_reg  <= acc6_reg[31];
            mag7_reg  <= acc6_reg[31] ? (~acc6_reg + 32'd1) : acc6_reg;
            lp7_reg   <= lp6_reg;
            hp7_reg   <= hp6_reg;
            dv7_reg   <= dv6_reg;
            sq7_reg   <= sq6_reg;

            prod8_reg <= {32'b0, mag7_reg} * {32'b0, RECIP};
            mag8_reg  <= mag7_reg;
            neg8_reg  <= neg7_reg;
            lp8_reg   <= lp7_reg;
            hp8_reg   <= hp7_reg;
            dv8_reg   <= dv7_reg;
            sq8_reg   <= sq7_reg;

            q9_reg    <= q0_est;
            r9_reg    <= mag8_reg - q0_est * WIN;
            neg9_reg  <= neg8_reg;
            lp9_reg   <= lp8_reg;
            hp9_reg   <= hp8_reg;
            dv9_reg   <= dv8_reg;
            sq9_reg   <= sq8_reg;

            lp10_reg  <= lp9_reg;
            hp10_reg  <= hp9_reg;
            dv10_reg  <= dv9_reg;
            sq10_reg  <= sq9_reg;
            avg10_reg <= avg_next;
        end
    end

    // output word
    assign out_valid   = v_reg[STAGES];
    assign low_passed  = lp10_reg;
    assign high_passed = hp10_reg;
    assign slope       = dv10_reg;
    assign squared     = sq10_reg;
    assign integrated  = avg10_reg;

endmodule

[rtl/qrs_preprocess_filter_chain.sv]
// Pan-Tompkins QRS preprocessing: each raw ECG word in gives one word out with the low-pass,
// high-pass, derivative, square and moving-window average of that sample. The block takes one
// word per clock while its queue has room and delivers one per clock while the output is not
// stalled. That rate is set by the recursions of the low-pass (one 64-bit add loop) and
// high-pass (one 32-bit add loop); the front computes the non-recursive low-pass term, a
// four-word queue separates it from the back pipeline, and the average is divided by the
// window length through a reciprocal multiply. All delay lines and the window sum are zero
// after reset, and there is no clearing pass.
module qrs_preprocess_filter_chain #(
    parameter int WINDOW_LEN  = qpf_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = qpf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] raw_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [63:0]            low_passed,
    output logic signed [31:0]            high_passed,
    output logic signed [31:0]            slope,
    output logic signed [31:0]            squared,
    output logic signed [31:0]            integrated
);
    import qpf_pkg::*;

    localparam int LQ_W = SAMPLE_BITS + LQ_EXTRA;

    q_status_t              q_status;
    logic                   push;
    logic signed [LQ_W-1:0] push_data;
    logic                   pop;
    logic        [LQ_W-1:0] head;

    // sample intake and low-pass input term
    qpf_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LQ_W        (LQ_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // decoupling queue
    qpf_queue #(
        .DATA_W (LQ_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    // filter pipeline
    qpf_back #(
        .WINDOW_LEN (WINDOW_LEN),
        .LQ_W       (LQ_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head        ($signed(head)),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .low_passed  (low_passed),
        .high_passed (high_passed),
        .slope       (slope),
        .squared     (squared),
        .integrated  (integrated)
    );

endmodule

[rtl/qpf_checker.sv]
module qpf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [63:0] low_passed,
    input logic signed [31:0] high_passed,
    input logic signed [31:0] slope,
    input logic signed [31:0] squared,
    input logic signed [31:0] integrated
);
    logic [7:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'b0, in_take} - {7'b0, out_take};
        end
    end

    // a held output word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(low_passed) && $stable(high_passed)
            && $stable(slope) && $stable(squared) && $stable(integrated))
        else $error("output word changed while stalled");

    // square field matches the slope field
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> squared == slope * slope)
        else $error("squared does not match slope");

    // no output word without a word taken for it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("output word with nothing pending");

    // an empty block never stalls its input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 8'd0 |-> !in_stall)
        else $error("input stalled while empty");

endmodule

bind qrs_preprocess_filter_chain qpf_checker u_qpf_checker (.*);

[tb/sv/tb_qrs_preprocess_filter_chain.sv]
`default_nettype none

module tb_qrs_preprocess_filter_chain;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN      = qpf_pkg::DEF_WINDOW_LEN;
    localparam int SBITS    = qpf_pkg::DEF_SAMPLE_BITS;
    localparam int DIR_N    = 20;
    localparam int RAND_N   = 800;
    localparam int TAIL_CYC = 40;

    // one result word of the chain
    typedef struct {
        logic signed [63:0] lp;
        logic signed [31:0] hp;
        logic signed [31:0] sl;
        logic signed [31:0] sq;
        logic signed [31:0] ig;
    } chain_out_t;

    // one stimulus row, with a typed expectation where one is given
    typedef struct {
        logic signed [SBITS-1:0] raw;
        bit                      has_exp;
        chain_out_t              exp_out;
    } sample_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [SBITS-1:0] raw_sample = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [63:0]      low_passed;
    logic signed [31:0]      high_passed;
    logic signed [31:0]      slope;
    logic signed [31:0]      squared;
    logic signed [31:0]      integrated;

    // filter state mirrored in the testbench
    logic signed [63:0] raw_hist [12];
    logic signed [63:0] lp_hist  [32];
    logic signed [31:0] hp_hist  [4];
    logic        [31:0] sq_ring  [WIN];
    int                 sq_pos;
    logic        [31:0] win_sum;

    chain_out_t pending_outputs [$];
    sample_row_t cur_row;
    sample_row_t dir_tab [DIR_N];

    int n_samples_in    = 0;
    int n_words_checked = 0;
    int n_mismatch      = 0;

    qrs_preprocess_filter_chain DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_sample  (raw_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .low_passed  (low_passed),
        .high_passed (high_passed),
        .slope       (slope),
        .squared     (squared),
        .integrated  (integrated)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // advance every stage by one sample and return its outputs
    function automatic chain_out_t chain_stage_outputs(logic signed [SBITS-1:0] s);
        logic signed [63:0] x, lq, lp, hsum, d, dq;
        logic signed [31:0] hp, dv, sq, ig;
        chain_out_t r;
        int i;
        x  = s;
        // low-pass, wraps at 64 bits
        lq = (x - 2 * raw_hist[5] + raw_hist[11]) / 32;
        lp = 2 * lp_hist[0] - lp_hist[1] + lq;
        // high-pass in 64 bits, kept to 32
        hsum = hp_hist[0] - lp / 32 + lp_hist[15] - lp_hist[16] + lp_hist[31] / 32;
        hp   = hsum[31:0];
        // five-point derivative, exact in 64 bits
        d  = 2 * hp + hp_hist[0] - hp_hist[2] - 2 * hp_hist[3];
        dq = d / 8;
        dv = dq[31:0];
        // square wraps at 32 bits
        sq = dv * dv;
        // running window sum
        win_sum         = win_sum - sq_ring[sq_pos] + sq;
        sq_ring[sq_pos] = sq;
        sq_pos          = (sq_pos + 1) % WIN;
        ig              = $signed(win_sum) / WIN;
        // shift delay lines
        for (i = 11; i > 0; i--)
            raw_hist[i] = raw_hist[i-1];
        raw_hist[0] = x;
        for (i = 31; i > 0; i--)
            lp_hist[i] = lp_hist[i-1];
        lp_hist[0] = lp;
        for (i = 3; i > 0; i--)
            hp_hist[i] = hp_hist[i-1];
        hp_hist[0] = hp;
        r.lp = lp;
        r.hp = hp;
        r.sl = dv;
        r.sq = sq;
        r.ig = ig;
        return r;
    endfunction

    task automatic cmp_field(string name, logic signed [63:0] e, logic signed [63:0] a);
        if (a !== e)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            n_mismatch++;
        end
    endtask

    // scoreboard: check output words, then queue the expectation of an accepted sample
    always @(posedge clk)
    begin : monitor
        chain_out_t e;
        chain_out_t p;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("output word with no expectation waiting");
                    n_mismatch++;
                end
                else
                begin
                    e = pending_outputs.pop_front();
                    cmp_field("low_passed", e.lp, low_passed);
                    cmp_field("high_passed", e.hp, high_passed);
                    cmp_field("slope", e.sl, slope);
                    cmp_field("squared", e.sq, squared);
                    cmp_field("integrated", e.ig, integrated);
                    n_words_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                p = chain_stage_outputs(raw_sample);
                pending_outputs.push_back(cur_row.has_exp ? cur_row.exp_out : p);
                n_samples_in++;
            end
        end
    end

    // receiver stall pattern, switching between modes
    always @(negedge clk)
    begin : receiver
        static int mode = 0;
        static int left = 0;
        static int cyc  = 0;
        if (left == 0)
        begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
        end
        left--;
        cyc++;
        case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 4) != 0);
            default: out_stall <= ((cyc % 7) < 3);
        endcase
    end

    // drive one word and hold it until it is taken
    task automatic send_word(sample_row_t row);
        @(negedge clk);
        cur_row = row;
        in_valid   <= 1'b1;
        raw_sample <= row.raw;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid   <= 1'b0;
            raw_sample <= SBITS'($urandom);
        end
    endtask

    // hold the sender until every expected word is out
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        sample_row_t row;
        logic signed [SBITS-1:0] v;
        logic signed [SBITS-1:0] hold;
        int k;
        int burst_left;
        int seg_kind;
        int seg_left;
        int per;
        int amp;

        // delay lines and window start at zero
        foreach (raw_hist[i]) raw_hist[i] = '0;
        foreach (lp_hist[i]) lp_hist[i] = '0;
        foreach (hp_hist[i]) hp_hist[i] = '0;
        foreach (sq_ring[i]) sq_ring[i] = '0;
        sq_pos  = 0;
        win_sum = '0;
        cur_row = '{'0, 1'b0, '{default: '0}};

        // directed rows: after reset, extremes, high-frequency swings, bit patterns
        dir_tab[ 0] = '{16'sd0,      1'b1, '{64'sd0,    32'sd0,   32'sd0,  32'sd0,  32'sd0}};
        dir_tab[ 1] = '{16'sd32767,  1'b1, '{64'sd1023, -32'sd31, -32'sd7, 32'sd49, 32'sd1}};
        dir_tab[ 2] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[ 3] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[ 4] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[ 5] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[ 6] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[ 7] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[ 8] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[ 9] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[10] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[11] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[12] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[13] = '{16'sd32767,  1'b0, '{default: '0}};
        dir_tab[14] = '{-16'sd32768, 1'b0, '{default: '0}};
        dir_tab[15] = '{16'sd1,      1'b0, '{default: '0}};
        dir_tab[16] = '{-16'sd1,     1'b0, '{default: '0}};
        dir_tab[17] = '{16'sd21845,  1'b0, '{default: '0}};
        dir_tab[18] = '{-16'sd21846, 1'b0, '{default: '0}};
        dir_tab[19] = '{16'sd0,      1'b0, '{default: '0}};

        // hold reset low, then release it
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_N; k++)
            send_word(dir_tab[k]);
        drain_outputs();

        // random part: signal segments of several shapes, sent in bursts
        burst_left = 0;
        seg_left   = 0;
        seg_kind   = 0;
        hold       = '0;
        per        = 1;
        amp        = 1;
        for (k = 0; k < RAND_N; k++)
        begin
            if (seg_left == 0)
            begin
                seg_kind = $urandom_range(0, 4);
                seg_left = $urandom_range(8, 60);
                hold     = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                per      = $urandom_range(1, 8);
                amp      = $urandom_range(1, 4000);
            end
            seg_left--;
            case (seg_kind)
                0: v = SBITS'($urandom);
                1: v = hold;
                2: v = ((k / per) % 2) ? 16'sh7fff : 16'sh8000;
                3: v = SBITS'(int'($urandom_range(0, 2 * amp)) - amp);
                default: v = ($urandom_range(0, 15) == 0) ? hold : 16'sd0;
            endcase

            if (burst_left == 0)
            begin
                idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
                burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 40);
            end
            burst_left--;

            if (k == RAND_N / 2)
                drain_outputs();

            row = '{v, 1'b0, '{default: '0}};
            send_word(row);
        end

        // let everything come out, then a short tail
        drain_outputs();
        repeat (TAIL_CYC) @(negedge clk);

        $display("samples sent: %0d (%0d directed, rest random segments); words checked: %0d",
                 n_samples_in, DIR_N, n_words_checked);
        $display("mismatches: %0d", n_mismatch);
        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words still expected", pending_outputs.size());
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
